FILE: design/dmzb_pkg.sv
// Shared types and constants for the depth map z-buffer merge block.
// Used by every module of the block but dmzb_ram; depends on nothing else.
`timescale 1ns / 1ps

package dmzb_pkg;

    // Frame store geometry.
    localparam int MAX_PIXELS = 524288;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int PIX_CNT_W  = ADDR_W + 1;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;

    // Configuration registers.
    localparam int NUM_SOURCES = 8;
    localparam int SRC_W       = 3;
    localparam int FRAME_W     = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SOURCE_ENABLE = 1'b0,
        REG_FRAME_PIXELS  = 1'b1
    } cfg_reg_t;

    localparam logic [NUM_SOURCES-1:0] SOURCE_ENABLE_RESET = 8'hFF;
    localparam logic [FRAME_W-1:0]     FRAME_PIXELS_RESET  = 20'd307200;

    // Stream widths.
    localparam int OP_W     = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_MERGE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Debug grey scale: floor(d * 255 / FULL_SCALE), saturated at 255.
    // The quotient is taken as (p * GREY_RECIP) >> GREY_SHIFT with p = d * 255,
    // which is exact for p below 2^22 because the reciprocal error stays under 2^14.
    localparam int          DISPLAY_FULL_SCALE = 14000;
    localparam int          GREY_P_W     = DEPTH_W + 8;
    localparam int          GREY_RECIP_W = 23;
    localparam int          GREY_PROD_W  = GREY_P_W + GREY_RECIP_W;
    localparam int          GREY_SHIFT   = 36;
    localparam longint      GREY_RECIP_L =
        ((64'd1 << GREY_SHIFT) + DISPLAY_FULL_SCALE - 1) / DISPLAY_FULL_SCALE;
    localparam logic [GREY_RECIP_W-1:0] GREY_RECIP = GREY_RECIP_L[GREY_RECIP_W-1:0];
    // Smallest depth whose grey level reaches 256 and therefore saturates.
    localparam int          SAT_DEPTH_I  = (256 * DISPLAY_FULL_SCALE + 254) / 255;
    localparam logic [DEPTH_W-1:0] SAT_DEPTH = SAT_DEPTH_I[DEPTH_W-1:0];

    // Item class decided by the front end.
    typedef enum logic [2:0] {
        K_MERGE,
        K_CLEAR,
        K_READ,
        K_OOR,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic                merge_en;
        logic [ADDR_W-1:0]   idx;
        logic [DEPTH_W-1:0]  depth;
    } item_t;

    // Head of the request queue, front to back.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // Back end control toward the front end.
    typedef struct packed {
        logic pop;
        logic init_busy;
    } back_ctrl_t;

    // One result; stored_depth sits in the lowest bits.
    typedef struct packed {
        logic                out_of_range;
        logic                written;
        logic [COLOR_W-1:0]  blue;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  red;
        logic [DEPTH_W-1:0]  stored_depth;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

FILE: design/dmzb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module dmzb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/dmzb_front.sv
// Front end: configuration registers, request intake, classification and a
// two-entry request queue toward the back end. Depends on dmzb_pkg.
`timescale 1ns / 1ps

module dmzb_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dmzb_pkg::OP_W-1:0]          s_tuser,
    input  logic [dmzb_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               cfg_wen,
    input  logic [dmzb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dmzb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  dmzb_pkg::back_ctrl_t               ctrl,
    output dmzb_pkg::queue_head_t              head,
    output logic [dmzb_pkg::FRAME_W-1:0]       frame_pixels
);

    logic [dmzb_pkg::NUM_SOURCES-1:0] source_enable_reg;
    logic [dmzb_pkg::FRAME_W-1:0]     frame_pixels_reg;

    dmzb_pkg::item_t   q_mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    dmzb_pkg::op_t                op;
    logic [dmzb_pkg::SRC_W-1:0]   src;
    logic [dmzb_pkg::ADDR_W-1:0]  idx;
    logic [dmzb_pkg::DEPTH_W-1:0] depth;
    logic                         in_range;
    logic                         src_en;
    dmzb_pkg::item_t              item;
    logic                         push;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_enable_reg <= dmzb_pkg::SOURCE_ENABLE_RESET;
            frame_pixels_reg  <= dmzb_pkg::FRAME_PIXELS_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (dmzb_pkg::cfg_reg_t'(cfg_index))
                dmzb_pkg::REG_SOURCE_ENABLE:
                    source_enable_reg <= cfg_wdata[dmzb_pkg::NUM_SOURCES-1:0];
                dmzb_pkg::REG_FRAME_PIXELS:
                    frame_pixels_reg  <= cfg_wdata[dmzb_pkg::FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    assign frame_pixels = frame_pixels_reg;

    // Field unpacking.
    assign op    = dmzb_pkg::op_t'(s_tuser);
    assign src   = s_tdata[dmzb_pkg::SRC_W-1:0];
    assign idx   = s_tdata[dmzb_pkg::SRC_W +: dmzb_pkg::ADDR_W];
    assign depth = s_tdata[dmzb_pkg::SRC_W + dmzb_pkg::ADDR_W +: dmzb_pkg::DEPTH_W];

    // The index is narrower than the active count, so comparing it with the
    // raw frame size already covers the cap at the store size.
    assign in_range = dmzb_pkg::FRAME_W'(idx) < frame_pixels_reg;
    assign src_en   = source_enable_reg[src];

    // Classification of the request.
    always_comb
    begin
        item.idx      = idx;
        item.depth    = depth;
        item.merge_en = src_en && (depth != '0);
        unique case (op)
            dmzb_pkg::OP_MERGE: item.kind = in_range ? dmzb_pkg::K_MERGE : dmzb_pkg::K_OOR;
            dmzb_pkg::OP_CLEAR: item.kind = dmzb_pkg::K_CLEAR;
            dmzb_pkg::OP_READ:  item.kind = in_range ? dmzb_pkg::K_READ : dmzb_pkg::K_OOR;
            default:            item.kind = dmzb_pkg::K_NOP;
        endcase
    end

    // Queue control.
    assign s_tready = !ctrl.init_busy && (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !ctrl.pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && ctrl.pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (ctrl.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

    assign head.valid = count_reg != 2'd0;
    assign head.item  = q_mem[rd_ptr_reg];

endmodule

FILE: design/dmzb_back.sv
// Back end: frame store sweeps, merge read-modify-write, debug grey scale
// and the output register. Depends on dmzb_pkg and dmzb_ram.
`timescale 1ns / 1ps

module dmzb_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dmzb_pkg::queue_head_t          head,
    input  logic [dmzb_pkg::FRAME_W-1:0]   frame_pixels,
    output dmzb_pkg::back_ctrl_t           ctrl,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dmzb_pkg::M_DATA_W-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_SCALE,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t                                state_reg, state_next;
    dmzb_pkg::item_t                       item_reg, item_next;
    logic [dmzb_pkg::PIX_CNT_W-1:0]        sweep_reg, sweep_next;
    dmzb_pkg::result_t                     res_reg, res_next;
    logic [dmzb_pkg::GREY_P_W-1:0]         p_reg, p_next;
    logic                                  sat_reg, sat_next;
    logic [dmzb_pkg::GREY_PROD_W-1:0]      prod_reg, prod_next;
    logic                                  out_valid_reg, out_valid_next;
    dmzb_pkg::result_t                     out_reg, out_next;

    logic [dmzb_pkg::PIX_CNT_W-1:0]        sweep_inc;
    logic [dmzb_pkg::PIX_CNT_W-1:0]        clear_count;
    logic [dmzb_pkg::COLOR_W-1:0]          grey;
    logic                                  pop;

    logic                                  ram_we;
    logic [dmzb_pkg::ADDR_W-1:0]           ram_waddr;
    logic [dmzb_pkg::DEPTH_W-1:0]          ram_wdata;
    logic                                  ram_re;
    logic [dmzb_pkg::ADDR_W-1:0]           ram_raddr;
    logic [dmzb_pkg::DEPTH_W-1:0]          cur;

    dmzb_ram #(
        .WIDTH (dmzb_pkg::DEPTH_W),
        .DEPTH (dmzb_pkg::MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (cur)
    );

    // Active pixel count, capped at the store size.
    assign clear_count =
        (frame_pixels >= dmzb_pkg::FRAME_W'(dmzb_pkg::MAX_PIXELS))
        ? dmzb_pkg::PIX_CNT_W'(dmzb_pkg::MAX_PIXELS)
        : dmzb_pkg::PIX_CNT_W'(frame_pixels);

    assign sweep_inc = sweep_reg + 1'b1;
    assign grey = sat_reg ? {dmzb_pkg::COLOR_W{1'b1}}
                          : prod_reg[dmzb_pkg::GREY_SHIFT +: dmzb_pkg::COLOR_W];

    // Sequencer and store access.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        sweep_next     = sweep_reg;
        res_next       = res_reg;
        p_next         = p_reg;
        sat_next       = sat_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = sweep_reg[dmzb_pkg::ADDR_W-1:0];
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = head.item.idx;

        unique case (state_reg)
            ST_INIT:
            begin
                // Zero the whole store after reset.
                ram_we     = 1'b1;
                sweep_next = sweep_inc;
                if (sweep_reg == dmzb_pkg::PIX_CNT_W'(dmzb_pkg::MAX_PIXELS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    item_next = head.item;
                    res_next  = '0;
                    unique case (head.item.kind) inside
                        dmzb_pkg::K_MERGE, dmzb_pkg::K_READ:
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_EVAL;
                        end
                        dmzb_pkg::K_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = (clear_count == '0) ? ST_DONE : ST_CLEAR;
                        end
                        dmzb_pkg::K_OOR:
                        begin
                            res_next.out_of_range = 1'b1;
                            state_next            = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_inc;
                if (sweep_inc == clear_count)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EVAL:
            begin
                res_next.stored_depth = cur;
                if (item_reg.kind == dmzb_pkg::K_MERGE)
                begin
                    // Keep the nearest nonzero depth.
                    if (item_reg.merge_en && ((cur == '0) || (cur > item_reg.depth)))
                    begin
                        ram_we                = 1'b1;
                        ram_waddr             = item_reg.idx;
                        ram_wdata             = item_reg.depth;
                        res_next.stored_depth = item_reg.depth;
                        res_next.written      = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else if (cur == '0)
                begin
                    // Empty pixel shows yellow.
                    res_next.red   = {dmzb_pkg::COLOR_W{1'b1}};
                    res_next.green = {dmzb_pkg::COLOR_W{1'b1}};
                    state_next     = ST_DONE;
                end
                else
                begin
                    p_next     = {cur, 8'h00} - {8'h00, cur};
                    sat_next   = cur >= dmzb_pkg::SAT_DEPTH;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = dmzb_pkg::GREY_PROD_W'(p_reg)
                           * dmzb_pkg::GREY_PROD_W'(dmzb_pkg::GREY_RECIP);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                res_next.red   = grey;
                res_next.green = grey;
                res_next.blue  = grey;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            item_reg      <= '0;
            sweep_reg     <= '0;
            res_reg       <= '0;
            p_reg         <= '0;
            sat_reg       <= 1'b0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            sweep_reg     <= sweep_next;
            res_reg       <= res_next;
            p_reg         <= p_next;
            sat_reg       <= sat_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign ctrl.pop       = pop;
    assign ctrl.init_busy = state_reg == ST_INIT;
    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = {{(dmzb_pkg::M_DATA_W - dmzb_pkg::RESULT_W){1'b0}}, out_reg};

endmodule

FILE: design/depth_map_zbuffer_merge_core.sv
// Top level of the depth map z-buffer merge block.
// Depends on dmzb_pkg, dmzb_front and dmzb_back.
`timescale 1ns / 1ps

// Usage
// Requests enter on the s_ stream: s_tuser carries the operation (merge,
// clear, read), s_tdata the source, pixel index and depth. Every request
// yields exactly one result on the m_ stream, in order.
// Configuration (source enables, frame size) is for the user to write through cfg_wen,
// cfg_index and cfg_wdata while no request is in flight; the block has no check for it.
// From request to result, a pixel outside the frame or a reserved operation
// goes from ST_IDLE straight to ST_DONE, a merge or a read of an empty pixel
// through the store read and ST_EVAL, a read of a nonzero pixel further through
// ST_MUL and ST_SCALE, and a clear through ST_CLEAR over the active pixel count.
// The back end handles one request at a time, so a merge waits until the previous
// request has left the fetch, compare and hand-over steps of the back end sequencer.
// A two-entry queue between intake and the back end keeps s_tready high
// while a request is being processed, until the queue holds two requests.
// After reset the frame store is zeroed, one pixel per cycle, over all
// 524288 pixels; s_tready stays low until then.
// When the receiver holds m_tready low, the result stays in the output
// register, the back end waits, and intake stops once the queue is full.

module depth_map_zbuffer_merge_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dmzb_pkg::OP_W-1:0]          s_tuser,   // op
    input  logic [dmzb_pkg::S_DATA_W-1:0]      s_tdata,   // source, pixel_index, depth, pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dmzb_pkg::M_DATA_W-1:0]      m_tdata,   // stored_depth, red, green, blue,
                                                          // written, out_of_range, pad
    input  logic                               cfg_wen,
    input  logic [dmzb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dmzb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    dmzb_pkg::queue_head_t         head;
    dmzb_pkg::back_ctrl_t          ctrl;
    logic [dmzb_pkg::FRAME_W-1:0]  frame_pixels;

    dmzb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .ctrl         (ctrl),
        .head         (head),
        .frame_pixels (frame_pixels)
    );

    dmzb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .frame_pixels (frame_pixels),
        .ctrl         (ctrl),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

FILE: design/dmzb_checker.sv
// Port-level checks for the depth map z-buffer merge block, bound to the top.
// Depends on dmzb_pkg and depth_map_zbuffer_merge_core.
`timescale 1ns / 1ps

module dmzb_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dmzb_pkg::M_DATA_W-1:0]  m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A pixel outside the frame reports nothing but the flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[41] |-> m_tdata[40:0] == '0)
        else $error("out of range result carries data");

    // A written merge holds a nonzero depth and no colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> m_tdata[39:16] == '0 && m_tdata[15:0] != '0)
        else $error("written merge result malformed");

    // Red and green always agree (yellow, grey or black).
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:16] == m_tdata[31:24])
        else $error("red and green differ");

endmodule

bind depth_map_zbuffer_merge_core dmzb_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb.sv
// Self-checking testbench for depth_map_zbuffer_merge_core: merge, clear and read requests.
// Results are predicted from a shadow frame store and compared in order; uses dmzb_pkg.
`timescale 1ns / 1ps

module tb;

    localparam logic [dmzb_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [dmzb_pkg::OP_W-1:0]    op;
        logic [dmzb_pkg::SRC_W-1:0]   src;
        logic [dmzb_pkg::ADDR_W-1:0]  pix;
        logic [dmzb_pkg::DEPTH_W-1:0] depth;
    } pixel_req_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [dmzb_pkg::OP_W-1:0]        s_tuser = '0;
    logic [dmzb_pkg::S_DATA_W-1:0]    s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [dmzb_pkg::M_DATA_W-1:0]    m_tdata;
    logic                             cfg_wen = 1'b0;
    logic [dmzb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dmzb_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Shadow copy of the frame store and of the configuration.
    bit [dmzb_pkg::DEPTH_W-1:0]       depth_mirror [dmzb_pkg::MAX_PIXELS];
    logic [dmzb_pkg::NUM_SOURCES-1:0] enable_mask = dmzb_pkg::SOURCE_ENABLE_RESET;
    logic [dmzb_pkg::FRAME_W-1:0]     frame_count = dmzb_pkg::FRAME_PIXELS_RESET;

    pixel_req_t         req_queue [$];
    dmzb_pkg::result_t  depth_expect [$];
    logic               req_taken = 1'b0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        err_cnt = 0;

    depth_map_zbuffer_merge_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Apply one request to the shadow store and return the result it should produce.
    function automatic dmzb_pkg::result_t zbuffer_result(
        logic [dmzb_pkg::OP_W-1:0] op, logic [dmzb_pkg::SRC_W-1:0] src,
        logic [dmzb_pkg::ADDR_W-1:0] pix, logic [dmzb_pkg::DEPTH_W-1:0] d);
        dmzb_pkg::result_t r;
        int unsigned       n;
        int unsigned       cur;
        int unsigned       grey;
        r = '0;
        n = (frame_count < dmzb_pkg::MAX_PIXELS) ? frame_count : dmzb_pkg::MAX_PIXELS;
        if (op == dmzb_pkg::OP_CLEAR)
        begin
            for (int unsigned i = 0; i < n; i++)
                depth_mirror[i] = '0;
            return r;
        end
        if (op == OP_RESERVED)
            return r;
        if (pix >= n)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        cur = depth_mirror[pix];
        if (op == dmzb_pkg::OP_MERGE)
        begin
            // A nonzero sample from an enabled source wins over an empty or farther pixel.
            if (enable_mask[src] && d != 0 && (cur == 0 || cur > d))
            begin
                depth_mirror[pix] = d;
                r.written = 1'b1;
            end
            r.stored_depth = depth_mirror[pix];
        end
        else
        begin
            r.stored_depth = dmzb_pkg::DEPTH_W'(cur);
            if (cur == 0)
            begin
                r.red   = 8'hFF;
                r.green = 8'hFF;
                r.blue  = 8'h00;
            end
            else
            begin
                grey = (cur * 255) / dmzb_pkg::DISPLAY_FULL_SCALE;
                if (grey > 255)
                    grey = 255;
                r.red   = grey[dmzb_pkg::COLOR_W-1:0];
                r.green = grey[dmzb_pkg::COLOR_W-1:0];
                r.blue  = grey[dmzb_pkg::COLOR_W-1:0];
            end
        end
        return r;
    endfunction

    // Random request: pixel mostly in [lo, hi], now and then anywhere in the index range.
    function automatic pixel_req_t random_request(int unsigned lo, int unsigned hi,
                                                  bit with_clear);
        pixel_req_t  q;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55)
            q.op = dmzb_pkg::OP_MERGE;
        else if (pick < 94)
            q.op = dmzb_pkg::OP_READ;
        else if (pick < 97 && with_clear)
            q.op = dmzb_pkg::OP_CLEAR;
        else
            q.op = OP_RESERVED;
        q.src = dmzb_pkg::SRC_W'($urandom_range(dmzb_pkg::NUM_SOURCES - 1));
        if ($urandom_range(7) == 0)
            q.pix = dmzb_pkg::ADDR_W'($urandom);
        else
            q.pix = dmzb_pkg::ADDR_W'($urandom_range(hi, lo));
        pick = $urandom_range(9);
        if (pick == 0)
            q.depth = '0;
        else if (pick < 6)
            q.depth = dmzb_pkg::DEPTH_W'($urandom_range(16000, 1));
        else if (pick < 9)
            q.depth = dmzb_pkg::DEPTH_W'($urandom);
        else
            q.depth = $urandom_range(1) ? 16'hFFFF : 16'd1;
        return q;
    endfunction

    task automatic add_req(logic [dmzb_pkg::OP_W-1:0] op, logic [dmzb_pkg::SRC_W-1:0] src,
                           logic [dmzb_pkg::ADDR_W-1:0] pix,
                           logic [dmzb_pkg::DEPTH_W-1:0] d);
        pixel_req_t q;
        q.op    = op;
        q.src   = src;
        q.pix   = pix;
        q.depth = d;
        req_queue = {req_queue, q};
    endtask

    // Configuration writes happen only with nothing in flight.
    task automatic write_reg(dmzb_pkg::cfg_reg_t idx, logic [dmzb_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == dmzb_pkg::REG_SOURCE_ENABLE)
            enable_mask = val[dmzb_pkg::NUM_SOURCES-1:0];
        else
            frame_count = val[dmzb_pkg::FRAME_W-1:0];
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    // Hold off until every request has been sent and every result has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_queue.size() != 0 || s_tvalid || depth_expect.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_phase(int unsigned count, int unsigned idle_pct, int unsigned stall_pct,
                             logic [dmzb_pkg::NUM_SOURCES-1:0] en,
                             logic [dmzb_pkg::FRAME_W-1:0] frame,
                             int unsigned lo, int unsigned hi, bit with_clear);
        write_reg(dmzb_pkg::REG_SOURCE_ENABLE, dmzb_pkg::CFG_DATA_W'(en));
        write_reg(dmzb_pkg::REG_FRAME_PIXELS, frame);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) req_queue = {req_queue, random_request(lo, hi, with_clear)};
        wait_idle();
    endtask

    // Request driver: holds a presented request until it is taken, idles at random.
    always @(negedge clk)
    begin
        if (req_taken)
            void'(req_queue.pop_front());
        if (s_tvalid && !req_taken)
        begin
            // Request still waiting for s_tready; keep it stable.
        end
        else if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= req_queue[0].op;
            s_tdata  <= {2'b00, req_queue[0].depth, req_queue[0].pix, req_queue[0].src};
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor and request capture.
    always @(posedge clk)
    begin
        dmzb_pkg::result_t got;
        dmzb_pkg::result_t want;
        req_taken <= s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[dmzb_pkg::RESULT_W-1:0];
            if (depth_expect.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: result with no request pending: depth %0d", $realtime,
                             got.stored_depth);
            end
            else
            begin
                want = depth_expect.pop_front();
                if (got.stored_depth !== want.stored_depth || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue ||
                    got.written !== want.written || got.out_of_range !== want.out_of_range)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch exp d=%0d rgb=%0d,%0d,%0d w=%0d oor=%0d",
                                 $realtime, want.stored_depth, want.red, want.green,
                                 want.blue, want.written, want.out_of_range);
                        $display("%0t:          got d=%0d rgb=%0d,%0d,%0d w=%0d oor=%0d",
                                 $realtime, got.stored_depth, got.red, got.green,
                                 got.blue, got.written, got.out_of_range);
                    end
                end
            end
        end
        if (rst_n && s_tvalid && s_tready)
            depth_expect = {depth_expect, zbuffer_result(s_tuser,
                s_tdata[dmzb_pkg::SRC_W-1:0],
                s_tdata[dmzb_pkg::SRC_W+dmzb_pkg::ADDR_W-1:dmzb_pkg::SRC_W],
                s_tdata[dmzb_pkg::SRC_W+dmzb_pkg::ADDR_W+dmzb_pkg::DEPTH_W-1:
                        dmzb_pkg::SRC_W+dmzb_pkg::ADDR_W])};
    end

    // Run limit well above the slowest correct run, including the store clearing after reset.
    initial
    begin
        #50_000_000;
        $display("depth_map_zbuffer_merge_core verification failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed requests with the reset configuration.
        add_req(dmzb_pkg::OP_READ, 0, 0, 0);
        add_req(dmzb_pkg::OP_MERGE, 0, 0, 1000);
        add_req(dmzb_pkg::OP_MERGE, 1, 0, 2000);
        add_req(dmzb_pkg::OP_MERGE, 2, 0, 500);
        add_req(dmzb_pkg::OP_MERGE, 3, 0, 0);
        add_req(dmzb_pkg::OP_MERGE, 7, 307199, 16'hFFFF);
        add_req(dmzb_pkg::OP_READ, 0, 307199, 0);
        add_req(dmzb_pkg::OP_MERGE, 4, 1, 14055);
        add_req(dmzb_pkg::OP_READ, 0, 1, 0);
        add_req(dmzb_pkg::OP_MERGE, 5, 1, 14054);
        add_req(dmzb_pkg::OP_READ, 0, 1, 0);
        add_req(dmzb_pkg::OP_MERGE, 6, 2, 1);
        add_req(dmzb_pkg::OP_READ, 0, 2, 0);
        add_req(dmzb_pkg::OP_MERGE, 0, 307200, 5);
        add_req(dmzb_pkg::OP_READ, 7, 19'h7FFFF, 16'hFFFF);
        add_req(OP_RESERVED, 7, 0, 16'hFFFF);
        add_req(dmzb_pkg::OP_READ, 0, 0, 0);
        wait_idle();

        // Small frame with some sources off: clear, disabled source, range edge.
        write_reg(dmzb_pkg::REG_SOURCE_ENABLE, 20'h5A);
        write_reg(dmzb_pkg::REG_FRAME_PIXELS, 20'd16);
        add_req(dmzb_pkg::OP_CLEAR, 0, 0, 0);
        add_req(dmzb_pkg::OP_READ, 0, 0, 0);
        add_req(dmzb_pkg::OP_MERGE, 0, 3, 77);
        add_req(dmzb_pkg::OP_MERGE, 1, 3, 77);
        add_req(dmzb_pkg::OP_READ, 0, 16, 0);
        add_req(dmzb_pkg::OP_MERGE, 6, 15, 300);
        wait_idle();

        // Pixels beyond the cleared region must have kept their depth.
        write_reg(dmzb_pkg::REG_FRAME_PIXELS, dmzb_pkg::FRAME_PIXELS_RESET);
        add_req(dmzb_pkg::OP_READ, 0, 307199, 0);
        wait_idle();

        // Random phases over several settings and idling patterns.
        run_phase(80, 0, 0, 8'hFF, 20'd64, 0, 70, 1'b1);
        begin
            logic [dmzb_pkg::FRAME_W-1:0] fp;
            fp = dmzb_pkg::FRAME_W'($urandom_range(200, 1));
            run_phase(70, 76, 0, dmzb_pkg::NUM_SOURCES'($urandom), fp, 0, fp + 5, 1'b1);
        end
        run_phase(60, 0, 76, dmzb_pkg::NUM_SOURCES'($urandom), 20'd524288, 524224, 524287,
                  1'b0);
        run_phase(20, 21, 21, dmzb_pkg::NUM_SOURCES'($urandom), 20'd0, 0, 40, 1'b1);
        run_phase(60, 21, 21, 8'hFF, 20'hFFFFF, 524256, 524287, 1'b0);
        run_phase(40, 0, 0, 8'h00, 20'd1, 0, 2, 1'b1);
        begin
            logic [dmzb_pkg::FRAME_W-1:0] fp;
            fp = dmzb_pkg::FRAME_W'($urandom_range(300, 100));
            run_phase(80, 21, 21, dmzb_pkg::NUM_SOURCES'($urandom), fp, 0, fp + 8, 1'b1);
        end

        repeat (10) @(negedge clk);
        if (err_cnt == 0 && depth_expect.size() == 0)
            $display("depth_map_zbuffer_merge_core verification clean");
        else
            $display("depth_map_zbuffer_merge_core verification failed");
        $finish;
    end

endmodule
